/* design/bra_pkg.sv */
package bra_pkg;
    localparam int NBITS     = 1024;
    localparam int WORD_BITS = 32;
    localparam int NWORDS    = NBITS / WORD_BITS;
    localparam int AW        = $clog2(NWORDS);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int IW        = $clog2(NBITS);
    localparam int LW        = IW + 1;

    localparam logic [2:0] K_SET_BIT  = 3'd0;
    localparam logic [2:0] K_FLIP     = 3'd1;
    localparam logic [2:0] K_TEST     = 3'd2;
    localparam logic [2:0] K_SET_RUN  = 3'd3;
    localparam logic [2:0] K_COUNT    = 3'd4;
    localparam logic [2:0] K_CONTAINS = 3'd5;
    localparam logic [2:0] K_SCAN     = 3'd6;
    localparam logic [2:0] K_SCAN_FL  = 3'd7;

    typedef struct packed {
        logic          range_error;
        logic          flag_out;
        logic [LW-1:0] tally;
        logic          found;
        logic [IW-1:0] found_index;
    } t_result;
endpackage

/* design/bitmap_run_allocator.sv */
// Bitmap run allocator: a 1024-bit map, cleared at reset, held in a 32x32 synchronous RAM.
// Every request works one bit position at a time over its range, each bit in three steps
// (read, wait, then use or write back). Range errors, empty runs and zero-length scans
// answer in the cycle after the word is accepted. A successful scan-and-flip then claims
// the run, one read-modify-write of its RAM word per bit. After reset a clearing pass
// zeroes all 32 RAM words before the first word is accepted. A result waits in an
// output register; the next word is taken once it has been read.
module bitmap_run_allocator
    import bra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // start_index[9:0], run_length[20:10], bit_value[21]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // found_index, found, tally, flag_out, range_error
);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OP   = 3'd4;
    localparam logic [2:0] S_FLIP = 3'd5;

    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa, mem_ra;
    logic [WORD_BITS-1:0] mem_wd;

    logic [2:0]    r_state, n_state;
    logic [10:0]   r_biu;
    logic [2:0]    r_kind;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_end;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_run, n_run;
    logic [IW-1:0] r_fidx, n_fidx;
    logic          r_val;
    logic [AW-1:0] r_clr;
    t_result       r_res, n_res;
    logic          r_ovalid, n_ovalid;

    logic [LW-1:0] lim;
    logic [IW-1:0] in_start;
    logic [LW-1:0] in_len;
    logic          in_val;
    logic          acc;
    logic [LW:0]   sum_end;
    logic          cur_bit;
    logic [WORD_BITS-1:0] wmask;
    logic          wbit;

    assign lim      = (r_biu > 11'(NBITS)) ? LW'(NBITS) : LW'(r_biu);
    assign in_start = s_axis_tdata[IW-1:0];
    assign in_len   = s_axis_tdata[IW+LW-1:IW];
    assign in_val   = s_axis_tdata[IW+LW];
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign sum_end  = (LW+1)'(in_start) + (LW+1)'(in_len);
    assign cur_bit  = r_rdata[r_pos[BW-1:0]];
    assign wmask    = WORD_BITS'(1) << r_pos[BW-1:0];
    assign mem_ra   = r_pos[IW-1:BW];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_run    = r_run;
        n_fidx   = r_fidx;
        n_res    = r_res;
        n_ovalid = r_ovalid && !m_axis_tready;
        mem_we   = 1'b0;
        mem_wa   = r_pos[IW-1:BW];
        mem_wd   = r_rdata;
        wbit     = r_val;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                if (r_clr == AW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_res  = '0;
                    n_pos  = LW'(in_start);
                    n_cnt  = '0;
                    n_run  = '0;
                    n_fidx = in_start;
                    if (s_axis_tuser <= K_TEST) begin
                        if (LW'(in_start) >= lim) begin
                            n_res.range_error = 1'b1;
                            n_ovalid = 1'b1;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (s_axis_tuser <= K_CONTAINS) begin
                        if (sum_end > (LW+1)'(lim)) begin
                            n_res.range_error = 1'b1;
                            n_ovalid = 1'b1;
                        end else if (in_len == '0) begin
                            n_ovalid = 1'b1;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        if (in_len > lim || LW'(in_start) > lim - in_len) begin
                            n_ovalid = 1'b1;
                        end else if (in_len == '0) begin
                            n_res.found = 1'b1;
                            n_res.found_index = in_start;
                            n_ovalid = 1'b1;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: n_state = S_WAIT;
            S_WAIT: n_state = S_OP;
            S_OP: begin
                priority case (r_kind)
                    K_SET_BIT, K_FLIP: begin
                        wbit   = (r_kind == K_FLIP) ? !cur_bit : r_val;
                        mem_we = 1'b1;
                        mem_wd = wbit ? (r_rdata | wmask) : (r_rdata & ~wmask);
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end
                    K_TEST: begin
                        n_res.flag_out = cur_bit;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end
                    K_SET_RUN, K_COUNT, K_CONTAINS: begin
                        if (r_kind == K_SET_RUN) begin
                            mem_we = 1'b1;
                            mem_wd = r_val ? (r_rdata | wmask) : (r_rdata & ~wmask);
                        end
                        n_cnt = r_cnt + LW'(cur_bit == r_val);
                        if (r_pos + 1'b1 == r_end) begin
                            if (r_kind == K_COUNT) begin
                                n_res.tally = n_cnt;
                            end
                            if (r_kind == K_CONTAINS) begin
                                n_res.flag_out = (n_cnt != '0);
                            end
                            n_ovalid = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_pos   = r_pos + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        if (cur_bit == r_val) begin
                            n_run = r_run + 1'b1;
                        end else begin
                            n_run = '0;
                        end
                        if (r_run == '0) begin
                            n_fidx = r_pos[IW-1:0];
                        end
                        if (n_run == r_len) begin
                            n_res.found = 1'b1;
                            n_res.found_index = (r_run == '0) ? r_pos[IW-1:0] : r_fidx;
                            if (r_kind == K_SCAN_FL) begin
                                n_pos   = (LW'(n_res.found_index));
                                n_cnt   = '0;
                                n_state = S_FLIP;
                            end else begin
                                n_ovalid = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end else if (r_pos + 1'b1 >= lim) begin
                            n_ovalid = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_pos   = r_pos + 1'b1;
                            n_state = S_RD;
                        end
                    end
                endcase
            end
            default: begin
                // flip claim: read, wait, then write one bit
                if (r_cnt[0] == 1'b1) begin
                    mem_we = 1'b1;
                    mem_wd = r_val ? (r_rdata & ~wmask) : (r_rdata | wmask);
                    n_cnt  = '0;
                    if (r_pos + 1'b1 == r_fidx + r_len) begin
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_pos = r_pos + 1'b1;
                        n_cnt = LW'(2);
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_biu    <= 11'd1024;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_clr    <= r_clr + 1'b1;
            if (i_cfg_we) begin
                r_biu <= i_cfg_wdata;
            end
        end
        r_pos  <= n_pos;
        r_cnt  <= (r_state == S_FLIP && r_cnt == LW'(2)) ? '0 : n_cnt;
        r_run  <= n_run;
        r_fidx <= (r_state == S_OP && n_state == S_FLIP) ? n_res.found_index : n_fidx;
        r_res  <= n_res;
        if (acc) begin
            r_kind <= s_axis_tuser;
            r_len  <= in_len;
            r_val  <= in_val;
            r_end  <= sum_end[LW-1:0];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_res;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("out moved");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we) else $error("write in idle");
endmodule
